// ===== hdl/pcx_rle_pkg.sv =====
// Shared types and constants for the PCX run-length encoder.
package pcx_rle_pkg;

   // Longest run that one code can carry
   localparam logic [5:0] RUN_MAX     = 6'd63;
   // Run code prefix; also the top-bits mask of a literal that needs a code
   localparam logic [7:0] RUN_CODE    = 8'hC0;
   // Depth of the run queue between front and back
   localparam int         QUEUE_DEPTH = 4;
   localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int         QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Input word
   typedef struct packed {
      logic [7:0] pixel;
      logic       row_end;
   } req_type;

   // Result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic       row_done;
   } rsp_type;

   // One closed run to be encoded
   typedef struct packed {
      logic       valid;
      logic [7:0] value;
      logic [5:0] length;
   } run_type;

   // Work for one pixel: up to two closed runs, in order
   typedef struct packed {
      run_type first;
      run_type second;
      logic    row_end;
   } entry_type;

   // Front-to-queue write port
   typedef struct packed {
      logic      push;
      entry_type entry;
   } push_type;

   // Queue-to-back read port
   typedef struct packed {
      logic      ready;
      entry_type entry;
   } head_type;

endpackage

// ===== hdl/pcx_rle_encoder.sv =====
// The first result word of a pixel passes through the run queue and the output register
// before it is offered.
// Throughput: one pixel per cycle; the back end sends one byte per cycle while rsp_stall is low,
// so pixels closing runs that need 2 to 4 bytes draw on a four-entry run queue and then stall.
// Reset (synchronous, active high) drops the open run, empties the queue and
// clears the output valid flag; there is no clearing pass.
module pcx_rle_encoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pcx_rle_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pcx_rle_pkg::rsp_type rsp_data
);

   pcx_rle_pkg::push_type push;
   pcx_rle_pkg::head_type head;
   logic                  queue_full;
   logic                  pop;

   pcx_rle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push_out   (push)
   );

   pcx_rle_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push),
      .full     (queue_full),
      .head_out (head),
      .pop      (pop)
   );

   pcx_rle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_in   (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/pcx_rle_front.sv =====
// Front end: accepts pixels, tracks the open run and emits closed runs.
module pcx_rle_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  pcx_rle_pkg::req_type  req_data,
   input  logic                  queue_full,
   output pcx_rle_pkg::push_type push_out
);

   logic [7:0] run_value_ff, run_value_in;
   logic [5:0] run_length_ff, run_length_in;
   logic       accept;
   logic       close_old;
   logic       close_new;
   logic [5:0] new_length;

   // Hold the input while the queue has no room
   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   // Classify the pixel against the open run
   always_comb begin
      close_old  = (run_length_ff != 6'd0) && (req_data.pixel != run_value_ff);
      new_length = (close_old || run_length_ff == 6'd0) ? 6'd1 : run_length_ff + 6'd1;
      close_new  = (new_length == pcx_rle_pkg::RUN_MAX) || req_data.row_end;

      run_value_in  = run_value_ff;
      run_length_in = run_length_ff;
      if (accept) begin
         run_value_in  = req_data.pixel;
         run_length_in = close_new ? 6'd0 : new_length;
      end
   end

   // Build the queue entry: the old run first, then the new one if it closes
   always_comb begin
      push_out.push                 = accept && (close_old || close_new);
      push_out.entry.row_end        = req_data.row_end;
      push_out.entry.second.valid   = 1'b0;
      push_out.entry.second.value   = req_data.pixel;
      push_out.entry.second.length  = new_length;
      if (close_old) begin
         push_out.entry.first.valid  = 1'b1;
         push_out.entry.first.value  = run_value_ff;
         push_out.entry.first.length = run_length_ff;
         push_out.entry.second.valid = close_new;
      end else begin
         push_out.entry.first.valid  = close_new;
         push_out.entry.first.value  = req_data.pixel;
         push_out.entry.first.length = new_length;
      end
   end

   // Hold the open run
   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff  <= 8'd0;
         run_length_ff <= 6'd0;
      end else begin
         run_value_ff  <= run_value_in;
         run_length_ff <= run_length_in;
      end
   end

   // A full-length run never stays open
   a_run_open_short : assert property (@(posedge clock) disable iff (reset)
      run_length_ff != pcx_rle_pkg::RUN_MAX)
      else $error("open run reached maximum length");

   // Every pushed entry carries at least its first run
   a_push_first : assert property (@(posedge clock) disable iff (reset)
      push_out.push |-> push_out.entry.first.valid)
      else $error("pushed entry without a run");

endmodule

// ===== hdl/pcx_rle_queue.sv =====
// Short queue of closed runs between front and back.
module pcx_rle_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  pcx_rle_pkg::push_type push_in,
   output logic                  full,
   output pcx_rle_pkg::head_type head_out,
   input  logic                  pop
);

   pcx_rle_pkg::entry_type slot_ff [pcx_rle_pkg::QUEUE_DEPTH];
   logic [pcx_rle_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [pcx_rle_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [pcx_rle_pkg::QUEUE_CW-1:0] count_ff, count_in;

   assign full           = count_ff == pcx_rle_pkg::QUEUE_CW'(pcx_rle_pkg::QUEUE_DEPTH);
   assign head_out.ready = count_ff != '0;
   assign head_out.entry = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push_in.push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push_in.push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_in.push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push_in.push) begin
         slot_ff[wr_ptr_ff] <= push_in.entry;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push_in.push |-> !full)
      else $error("push into full queue");

   a_no_underflow : assert property (@(posedge clock) disable iff (reset)
      pop |-> head_out.ready)
      else $error("pop from empty queue");

endmodule

// ===== hdl/pcx_rle_back.sv =====
// Back end: expands queued runs into PCX bytes through an output register.
module pcx_rle_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pcx_rle_pkg::head_type head_in,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pcx_rle_pkg::rsp_type  rsp_data
);

   logic [1:0]           idx_ff, idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pcx_rle_pkg::rsp_type rsp_data_ff, rsp_data_in;

   pcx_rle_pkg::run_type run_sel;
   logic       two_first, two_second, two_sel;
   logic [2:0] n_first, n_second, n_total, idx_wide, pos;
   logic       final_byte;
   logic       load;

   // A run needs a code byte unless it is a single byte whose top two bits are not both set
   function automatic logic needs_code(input pcx_rle_pkg::run_type r);
      return (r.length != 6'd1) ||
             ((r.value & pcx_rle_pkg::RUN_CODE) == pcx_rle_pkg::RUN_CODE);
   endfunction

   // Pick the byte at the current position of the head entry
   always_comb begin
      two_first  = needs_code(head_in.entry.first);
      two_second = needs_code(head_in.entry.second);
      n_first    = two_first ? 3'd2 : 3'd1;
      n_second   = head_in.entry.second.valid ? (two_second ? 3'd2 : 3'd1) : 3'd0;
      n_total    = n_first + n_second;
      idx_wide   = {1'b0, idx_ff};
      if (idx_wide < n_first) begin
         run_sel = head_in.entry.first;
         two_sel = two_first;
         pos     = idx_wide;
      end else begin
         run_sel = head_in.entry.second;
         two_sel = two_second;
         pos     = idx_wide - n_first;
      end
      final_byte = idx_wide == (n_total - 3'd1);
   end

   // Load the output register when the queue has an entry and the register is empty or being taken
   assign load = head_in.ready && (!rsp_valid_ff || !rsp_stall);
   assign pop  = load && final_byte;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         idx_in       = final_byte ? 2'd0 : idx_ff + 2'd1;
         rsp_valid_in = 1'b1;
         rsp_data_in.out_byte = (pos == 3'd0 && two_sel)
                                ? (pcx_rle_pkg::RUN_CODE | {2'b00, run_sel.length})
                                : run_sel.value;
         rsp_data_in.last     = final_byte;
         rsp_data_in.row_done = final_byte && head_in.entry.row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Position stays inside the head entry's byte list
   a_idx_bound : assert property (@(posedge clock) disable iff (reset)
      head_in.ready |-> ({1'b0, idx_ff} < n_total))
      else $error("byte position beyond entry");

   // Position returns to zero once the entry leaves the queue
   a_idx_wrap : assert property (@(posedge clock) disable iff (reset)
      pop |=> idx_ff == 2'd0)
      else $error("position not cleared after pop");

endmodule
